[src/iisb_pkg.sv]
// shared types and constants of the indexed insert sequence buffer
package iisb_pkg;

   localparam int POS_W   = 7;
   localparam int VALUE_W = 32;

   typedef enum logic [1:0] {
      STATUS_ELEM    = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_ROT_LEFT,
      CELL_ROT_RIGHT
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FWD,
      ST_REV,
      ST_STATUS
   } ctl_state_type;

   typedef struct packed {
      logic signed [POS_W-1:0]   position;
      logic signed [VALUE_W-1:0] value;
   } req_word_type;

   typedef struct packed {
      status_type                status;
      logic                      direction;
      logic signed [VALUE_W-1:0] element;
      logic                      last;
   } rsp_word_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      cell_op_type               op;
      logic [POS_W-1:0]          pos;
      logic [POS_W-1:0]          tail;
      logic signed [VALUE_W-1:0] value;
   } cell_ctl_type;

endpackage

[src/iisb_cell.sv]
// one storage cell of the chain, takes from its neighbors on insert and rotate
module iisb_cell
   import iisb_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic                      clock,
   input  cell_ctl_type              ctl,
   input  logic signed [VALUE_W-1:0] prev_value,
   input  logic signed [VALUE_W-1:0] next_value,
   input  logic signed [VALUE_W-1:0] head_value,
   output logic signed [VALUE_W-1:0] value
);

   localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (MY_IDX == ctl.pos) begin
               value_in = ctl.value;
            end else if (MY_IDX > ctl.pos) begin
               value_in = prev_value;
            end
         end
         CELL_ROT_LEFT: begin
            // tail of the live region wraps around to the old head
            if (MY_IDX == ctl.tail) begin
               value_in = head_value;
            end else begin
               value_in = next_value;
            end
         end
         CELL_ROT_RIGHT: begin
            value_in = prev_value;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

[src/iisb_ctrl.sv]
// sequencer: position check, count, listing passes and the result register
module iisb_ctrl
   import iisb_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_word_type              req_word,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_word_type              rsp_word,
   input  logic signed [VALUE_W-1:0] head_value,
   input  logic signed [VALUE_W-1:0] tail_value,
   output cell_ctl_type              cell_ctl
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   ctl_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] k_ff, k_in;
   status_type       status_ff, status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_word_ff, rsp_word_in;

   logic             out_free;
   logic             load_rsp;
   logic             pos_ok;
   logic             full;
   logic             pass_end;
   logic [POS_W-1:0] pos_u;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pos_u    = POS_W'(req_word.position);
   assign pos_ok   = !req_word.position[POS_W-1] && (pos_u <= POS_W'(count_ff));
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign pass_end = (k_ff == count_ff - CNT_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (pos_ok && !full) ? ST_FWD : ST_STATUS;
            end
         end
         ST_FWD: begin
            if (out_free && pass_end) begin
               state_in = ST_REV;
            end
         end
         ST_REV: begin
            if (out_free && pass_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_stall          = 1'b1;
      load_rsp           = 1'b0;
      count_in           = count_ff;
      k_in               = k_ff;
      status_in          = status_ff;
      rsp_word_in        = rsp_word_ff;
      cell_ctl.op        = CELL_HOLD;
      cell_ctl.pos       = pos_u;
      cell_ctl.tail      = POS_W'(count_ff) - POS_W'(1);
      cell_ctl.value     = req_word.value;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            k_in      = '0;
            if (req_valid) begin
               if (!pos_ok) begin
                  status_in = STATUS_INVALID;
               end else if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  cell_ctl.op = CELL_INSERT;
                  count_in    = count_ff + CNT_W'(1);
               end
            end
         end
         ST_FWD: begin
            if (out_free) begin
               load_rsp                = 1'b1;
               rsp_word_in.status      = STATUS_ELEM;
               rsp_word_in.direction   = 1'b0;
               rsp_word_in.element     = head_value;
               rsp_word_in.last        = 1'b0;
               cell_ctl.op             = CELL_ROT_LEFT;
               k_in                    = pass_end ? '0 : k_ff + CNT_W'(1);
            end
         end
         ST_REV: begin
            if (out_free) begin
               load_rsp                = 1'b1;
               rsp_word_in.status      = STATUS_ELEM;
               rsp_word_in.direction   = 1'b1;
               rsp_word_in.element     = tail_value;
               rsp_word_in.last        = pass_end;
               cell_ctl.op             = CELL_ROT_RIGHT;
               k_in                    = k_ff + CNT_W'(1);
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               load_rsp                = 1'b1;
               rsp_word_in.status      = status_ff;
               rsp_word_in.direction   = 1'b0;
               rsp_word_in.element     = '0;
               rsp_word_in.last        = 1'b1;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
      rsp_valid_in = out_free ? load_rsp : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[src/indexed_insert_sequence_buffer.sv]
// Indexed insert sequence buffer: an ordered list of signed words held in a chain of cells.
//
// A req word carries a signed position and a value. One word is taken at a
// time: req_stall stays high from acceptance until the last result has been
// loaded into the rsp register. A position below zero or above the stored count
// gives one rsp word with status invalid; a good position while DEPTH values are
// stored gives one word with status full. Either leaves the list unchanged.
// A good insert shifts the cells at and after the position back by one in the
// accept cycle, then lists the whole sequence front to back (direction 0) and
// back to front (direction 1), last set on the final word.
// Timing: the insert is written in the accept cycle, then one rsp word per cycle
// while the receiver does not stall. The cell chain rotates by one place per
// listed word, which sets the one word per cycle pace. After acceptance the
// state register moves on to the forward pass, which loads the first rsp word
// into the rsp register.
// rsp_stall freezes the rsp register and the chain; nothing is lost or repeated.
// Reset empties the list at once; cell contents need no clearing.
module indexed_insert_sequence_buffer
   import iisb_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int IDX_W = $clog2(DEPTH);

   cell_ctl_type              cell_ctl;
   logic signed [VALUE_W-1:0] cell_value [DEPTH];
   logic signed [VALUE_W-1:0] tail_value;

   assign tail_value = cell_value[cell_ctl.tail[IDX_W-1:0]];

   iisb_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word),
      .head_value (cell_value[0]),
      .tail_value (tail_value),
      .cell_ctl   (cell_ctl)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VALUE_W-1:0] prev_value;
      logic signed [VALUE_W-1:0] next_value;

      // the head's upstream neighbor is the tail, so a right rotate wraps
      if (i == 0) begin : g_head
         assign prev_value = tail_value;
      end else begin : g_body
         assign prev_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_end
         assign next_value = cell_value[0];
      end else begin : g_mid
         assign next_value = cell_value[i+1];
      end

      iisb_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .prev_value (prev_value),
         .next_value (next_value),
         .head_value (cell_value[0]),
         .value      (cell_value[i])
      );
   end

endmodule

[src/iisb_checker.sv]
// port-level checks of the indexed insert sequence buffer and its bind
module iisb_checker
   import iisb_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_word_type req_word,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   // a stalled req word holds until it is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_word))
      else $error("req word changed while stalled");

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   // one word in flight: an accepted req closes the input side
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req accepted back to back");

   // status words are single, zero and forward
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != STATUS_ELEM |->
         rsp_word.last && rsp_word.element == '0 && !rsp_word.direction)
      else $error("malformed status word");

   // the forward pass never ends a listing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == STATUS_ELEM && !rsp_word.direction |-> !rsp_word.last)
      else $error("last set in forward pass");

endmodule

bind indexed_insert_sequence_buffer iisb_checker u_iisb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
